### hw/rtl/rfq_pkg.sv
`timescale 1ns / 1ps
package rfq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;
  localparam int KIND_W    = 2;
  localparam int CNT_W_DEF = $clog2(DEPTH_DEF + 1);

  localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQUEUE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REVERSE = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // take the input word
    logic exec;      // apply the operation, read old front
    logic front_rd;  // read new front, capture popped data
    logic load_out;  // fill the output register
  } cmd_t;

endpackage

### hw/rtl/rfq_if.sv
`timescale 1ns / 1ps
interface rfq_in_if;
  logic                              valid;
  logic                              ready;
  logic        [rfq_pkg::KIND_W-1:0] kind;
  logic signed [rfq_pkg::VAL_W-1:0]  value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface rfq_out_if #(
  parameter int CNT_W = rfq_pkg::CNT_W_DEF
);
  logic                             valid;
  logic                             ready;
  logic signed [rfq_pkg::VAL_W-1:0] popped_value;
  logic                             popped_valid;
  logic                             empty_error;
  logic                             full_error;
  logic signed [rfq_pkg::VAL_W-1:0] front_value;
  logic                             front_valid;
  logic        [CNT_W-1:0]          item_count;

  modport source (output valid, popped_value, popped_valid, empty_error, full_error,
                  front_value, front_valid, item_count, input ready);
  modport sink   (input valid, popped_value, popped_valid, empty_error, full_error,
                  front_value, front_valid, item_count, output ready);
endinterface

### hw/rtl/reversible_fifo_queue_unit.sv
`timescale 1ns / 1ps
// Steps per word: take, two reads (old front, new front) through the single
// registered read port of the ring RAM, then output load, which waits until
// the output slot is free. A new word is taken only once the last one is through;
// it is taken while the previous result still waits at the output.
// Reset (sync, active low) empties the queue and sets forward order; ring
// contents are left as they are and are only read after being written.
module reversible_fifo_queue_unit #(
  parameter int DEPTH = rfq_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rfq_in_if.sink    in_ch,
  rfq_out_if.source out_ch
);
  import rfq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             cmd;
  logic [CNT_W-1:0] item_count;

  rfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  rfq_dp #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_kind          (in_ch.kind),
    .in_value         (in_ch.value),
    .out_popped_value (out_ch.popped_value),
    .out_popped_valid (out_ch.popped_valid),
    .out_empty_error  (out_ch.empty_error),
    .out_full_error   (out_ch.full_error),
    .out_front_value  (out_ch.front_value),
    .out_front_valid  (out_ch.front_valid),
    .out_item_count   (item_count)
  );

  assign out_ch.item_count = item_count;

endmodule

### hw/rtl/rfq_ram.sv
`timescale 1ns / 1ps
module rfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/rfq_ctrl.sv
`timescale 1ns / 1ps
module rfq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output rfq_pkg::cmd_t cmd
);
  import rfq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FRONT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // output slot frees up in the same cycle it is taken
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_FRONT;
      end
      S_FRONT: begin
        cmd.front_rd = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### hw/rtl/rfq_dp.sv
`timescale 1ns / 1ps
module rfq_dp #(
  parameter int DEPTH = rfq_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rfq_pkg::cmd_t                    cmd,
  input  logic        [rfq_pkg::KIND_W-1:0] in_kind,
  input  logic signed [rfq_pkg::VAL_W-1:0]  in_value,
  output logic signed [rfq_pkg::VAL_W-1:0]  out_popped_value,
  output logic                             out_popped_valid,
  output logic                             out_empty_error,
  output logic                             out_full_error,
  output logic signed [rfq_pkg::VAL_W-1:0]  out_front_value,
  output logic                             out_front_valid,
  output logic        [CNT_W-1:0]          out_item_count
);
  import rfq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // slot that lies off entries behind front, wrapping at DEPTH
  function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] front,
                                               input logic [IDX_W-1:0] off,
                                               input logic             rev);
    logic [IDX_W:0] s;
    begin
      if (rev) begin
        if (front >= off) s = {1'b0, front} - {1'b0, off};
        else              s = {1'b0, front} + DEPTH_X - {1'b0, off};
      end else begin
        s = {1'b0, front} + {1'b0, off};
        if (s >= DEPTH_X) s = s - DEPTH_X;
      end
      slot_at = s[IDX_W-1:0];
    end
  endfunction

  logic [KIND_W-1:0] kind_r;
  logic [VAL_W-1:0]  value_r;
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              rev_r, rev_nxt;
  logic              pop_vld_r, pop_vld_nxt;
  logic              empty_err_r, empty_err_nxt;
  logic              full_err_r, full_err_nxt;
  logic [VAL_W-1:0]  pop_data_r;

  logic              is_full, is_empty;
  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  rear_slot;
  logic              ram_we, ram_re;
  logic [VAL_W-1:0]  ram_rdata;

  assign is_full   = (count_r == DEPTH_C);
  assign is_empty  = (count_r == '0);
  assign cnt_m1    = count_r - CNT_W'(1);
  assign rear_slot = slot_at(front_r, count_r[IDX_W-1:0], rev_r);

  always_comb begin
    front_nxt     = front_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    pop_vld_nxt   = pop_vld_r;
    empty_err_nxt = empty_err_r;
    full_err_nxt  = full_err_r;
    ram_we        = 1'b0;
    if (cmd.exec) begin
      pop_vld_nxt   = 1'b0;
      empty_err_nxt = 1'b0;
      full_err_nxt  = 1'b0;
      case (kind_r)
        KIND_ENQUEUE: begin
          if (is_full) begin
            full_err_nxt = 1'b1;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        KIND_DEQUEUE: begin
          if (is_empty) begin
            empty_err_nxt = 1'b1;
          end else begin
            pop_vld_nxt = 1'b1;
            front_nxt   = slot_at(front_r, IDX_W'(1), rev_r);
            count_nxt   = cnt_m1;
          end
        end
        KIND_REVERSE: begin
          if (!is_empty) begin
            front_nxt = slot_at(front_r, cnt_m1[IDX_W-1:0], rev_r);
          end
          rev_nxt = !rev_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      pop_vld_r   <= 1'b0;
      empty_err_r <= 1'b0;
      full_err_r  <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      pop_vld_r   <= pop_vld_nxt;
      empty_err_r <= empty_err_nxt;
      full_err_r  <= full_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r  <= in_kind;
      value_r <= in_value;
    end
    // read issued in exec returns the old front
    if (cmd.front_rd) begin
      pop_data_r <= ram_rdata;
    end
    if (cmd.load_out) begin
      out_popped_value <= pop_vld_r ? pop_data_r : '0;
      out_popped_valid <= pop_vld_r;
      out_empty_error  <= empty_err_r;
      out_full_error   <= full_err_r;
      out_front_value  <= is_empty ? '0 : ram_rdata;
      out_front_valid  <= !is_empty;
      out_item_count   <= count_r;
    end
  end

  assign ram_re = cmd.exec || cmd.front_rd;

  rfq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rear_slot),
    .wdata (value_r),
    .re    (ram_re),
    .raddr (front_r),
    .rdata (ram_rdata)
  );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rfq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int SEGMENTS    = 14;
  localparam int SEG_WORDS   = 50;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [VAL_W-1:0] popped_value;
    logic                    popped_valid;
    logic                    empty_error;
    logic                    full_error;
    logic signed [VAL_W-1:0] front_value;
    logic                    front_valid;
    logic [CNT_W_DEF-1:0]    item_count;
  } queue_result_t;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic clk;
  logic rst_n;

  rfq_in_if  in_ch ();
  rfq_out_if out_ch ();

  reversible_fifo_queue_unit #(.DEPTH(DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // shadow queue state
  logic signed [VAL_W-1:0] ring_copy [DEPTH];
  logic [IDX_W-1:0]        head_slot;
  int                      fill_level;
  logic                    flipped;

  queue_result_t expected_q [$];

  int       err_count;
  int       idle_cycles;
  int       burst_left;
  bit       tx_gaps_on;
  rx_mode_t rx_mode;
  int       hold_req;
  int       hold_left;
  int       rx_phase;
  logic [7:0] rx_pattern = 8'b1101_0011;

  int n_enq, n_deq, n_rev, n_unused, n_full, n_empty, peak_fill;

  function automatic logic [IDX_W-1:0] slot_of(int offset);
    int off;
    off = offset % DEPTH;
    if (flipped)
      return IDX_W'((int'(head_slot) + DEPTH - off) % DEPTH);
    return IDX_W'((int'(head_slot) + off) % DEPTH);
  endfunction

  function automatic queue_result_t apply_op(logic [KIND_W-1:0] kind,
                                             logic signed [VAL_W-1:0] value);
    queue_result_t r;
    r = '0;
    case (kind)
      KIND_ENQUEUE: begin
        if (fill_level >= DEPTH) begin
          r.full_error = 1'b1;
        end else begin
          ring_copy[slot_of(fill_level)] = value;
          fill_level++;
        end
      end
      KIND_DEQUEUE: begin
        if (fill_level == 0) begin
          r.empty_error = 1'b1;
        end else begin
          r.popped_value = ring_copy[head_slot];
          r.popped_valid = 1'b1;
          head_slot = slot_of(1);
          fill_level--;
        end
      end
      KIND_REVERSE: begin
        // front moves to the old rear; empty queue only flips direction
        if (fill_level != 0) head_slot = slot_of(fill_level - 1);
        flipped = ~flipped;
      end
      default: ;
    endcase
    if (fill_level != 0) begin
      r.front_value = ring_copy[head_slot];
      r.front_valid = 1'b1;
    end
    r.item_count = CNT_W_DEF'(fill_level);
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(int enq_weight);
    int r;
    r = $urandom_range(0, 99);
    if (r < enq_weight) return KIND_ENQUEUE;
    if (r < enq_weight + 10) return KIND_REVERSE;
    if (r < enq_weight + 13) return KIND_UNUSED;
    return KIND_DEQUEUE;
  endfunction

  task automatic send_word(input logic [KIND_W-1:0] kind,
                           input logic signed [VAL_W-1:0] value);
    queue_result_t r;
    int gap;
    if (tx_gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk) in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    r = apply_op(kind, value);
    expected_q.push_back(r);
    case (kind)
      KIND_ENQUEUE: n_enq++;
      KIND_DEQUEUE: n_deq++;
      KIND_REVERSE: n_rev++;
      default:      n_unused++;
    endcase
    if (r.full_error) n_full++;
    if (r.empty_error) n_empty++;
    if (fill_level > peak_fill) peak_fill = fill_level;
  endtask

  // drop valid, then let every outstanding word come back
  task automatic wait_drain();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    tx_gaps_on = 1'b0;
    rx_mode    = RX_OPEN;
    send_word(KIND_DEQUEUE, 32'sh1234_5678);
    send_word(KIND_REVERSE, -32'sd1);
    send_word(KIND_UNUSED, 32'sh7FFF_FFFF);
    wait_drain();
  endtask

  task automatic test_fill_and_overflow();
    logic signed [VAL_W-1:0] fixed_vals [8];
    fixed_vals = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1,
                   32'sh5555_5555, 32'shAAAA_AAAA, 32'sd1, -32'sd2};
    tx_gaps_on = 1'b1;
    rx_mode    = RX_RANDOM;
    for (int i = 0; i < DEPTH; i++)
      send_word(KIND_ENQUEUE, (i < 8) ? fixed_vals[i] : $urandom);
    send_word(KIND_ENQUEUE, 32'sh0BAD_0BAD);  // full: dropped
    send_word(KIND_REVERSE, '0);
    send_word(KIND_DEQUEUE, '0);
    send_word(KIND_DEQUEUE, -32'sd1);
    send_word(KIND_UNUSED, '0);
    send_word(KIND_ENQUEUE, 32'sh8000_0001);  // enqueue in reversed order
    wait_drain();
  endtask

  task automatic test_random_mix();
    int enq_weight;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(0, 2))
        0: enq_weight = 25;
        1: enq_weight = 50;
        default: enq_weight = 75;
      endcase
      if (seg == 0) begin
        tx_gaps_on = 1'b0;
        rx_mode    = RX_OPEN;
      end else begin
        tx_gaps_on = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 2))
          0: rx_mode = RX_OPEN;
          1: rx_mode = RX_RANDOM;
          default: rx_mode = RX_PATTERN;
        endcase
      end
      for (int i = 0; i < SEG_WORDS; i++)
        send_word(pick_kind(enq_weight), pick_value());
    end
    wait_drain();
  endtask

  // result side stops for a long stretch while words keep coming
  task automatic test_output_hold_off();
    tx_gaps_on = 1'b0;
    rx_mode    = RX_RANDOM;
    hold_req   = HOLD_CYCLES;
    for (int i = 0; i < 40; i++)
      send_word(pick_kind(50), pick_value());
    wait_drain();
  endtask

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    rx_phase++;
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_RANDOM: out_ch.ready <= ($urandom_range(0, 99) >= 35);
        default:   out_ch.ready <= rx_pattern[rx_phase[2:0]];
      endcase
    end
  end

  task automatic check_field(input string name, input logic signed [63:0] exp_v,
                             input logic signed [63:0] got_v);
    if (exp_v !== got_v) begin
      err_count++;
      if (err_count <= 30)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    queue_result_t exp_r;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        err_count++;
        $display("%0t ns: result word with nothing pending, got front %0d count %0d",
                 $time, out_ch.front_value, out_ch.item_count);
      end else begin
        exp_r = expected_q.pop_front();
        check_field("popped_value", exp_r.popped_value, out_ch.popped_value);
        check_field("popped_valid", exp_r.popped_valid, out_ch.popped_valid);
        check_field("empty_error", exp_r.empty_error, out_ch.empty_error);
        check_field("full_error", exp_r.full_error, out_ch.full_error);
        check_field("front_value", exp_r.front_value, out_ch.front_value);
        check_field("front_valid", exp_r.front_valid, out_ch.front_valid);
        check_field("item_count", exp_r.item_count, out_ch.item_count);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles, %0d results pending",
               $time, idle_cycles, expected_q.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_ENQUEUE;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    rx_mode      = RX_OPEN;
    head_slot    = '0;
    fill_level   = 0;
    flipped      = 1'b0;
    foreach (ring_copy[i]) ring_copy[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_empty_queue();
    test_fill_and_overflow();
    test_random_mix();
    test_output_hold_off();
    wait_drain();

    $display("covered %0d words: %0d enqueue, %0d dequeue, %0d reverse, %0d unused kind",
             n_enq + n_deq + n_rev + n_unused, n_enq, n_deq, n_rev, n_unused);
    $display("%0d dropped on full, %0d dequeues on empty, peak fill %0d of %0d, %0d errors",
             n_full, n_empty, peak_fill, DEPTH, err_count);
    if (err_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
